// ===== hdl/rldr_pkg.sv =====
package rldr_pkg;

  localparam int MAX_DIM = 4096;
  localparam int PIPE_DEPTH = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_CENTER_OFFSET_X = 3'd2,
    REG_CENTER_OFFSET_Y = 3'd3,
    REG_COEFF_FIRST     = 3'd4,
    REG_COEFF_SECOND    = 3'd5,
    REG_COEFF_THIRD     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [11:0] mapped_x;
    logic [11:0] mapped_y;
    logic [23:0] mapped_index;
    logic        in_frame;
  } result_t;

endpackage

// ===== hdl/radial_lens_distortion_remap_core.sv =====
// a pixel taken with start is shown on result at the end of the pipeline, marked by result_valid
// throughput: one pixel per clock while busy is low, set by the 17 stage multiply and add pipeline
// busy is high only in the cycle after a reset cycle
// reset (synchronous, rst high) empties the pipeline and loads the register defaults
// result_valid is a one cycle strobe and the receiver cannot stall it
module radial_lens_distortion_remap_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rldr_pkg::pixel_t                    pixel,
  output logic                                result_valid,
  output rldr_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [rldr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rldr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rldr_pkg::*;

  // configuration registers
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [16:0] center_offset_x;
  logic [16:0] center_offset_y;
  logic [31:0] coeff_first;
  logic [31:0] coeff_second;
  logic [31:0] coeff_third;

  logic [12:0] wc;
  logic [12:0] hc;
  logic [17:0] cx;
  logic [17:0] cy;
  logic [31:0] k1_mag;
  logic [31:0] k2_mag;
  logic [31:0] k3_mag;

  logic [PIPE_DEPTH-1:0] vld;

  // stage registers
  logic        ok1, ok2, ok3, ok4, ok5, ok6, ok7, ok8, ok9, ok10, ok11, ok12, ok13, ok14;
  logic        ok15, ok16;
  logic [18:0] dx1, dx2, dx3, dx4, dx5, dx6, dx7, dx8, dx9, dx10, dx11;
  logic [18:0] dy1, dy2, dy3, dy4, dy5, dy6, dy7, dy8, dy9, dy10, dy11;
  logic [35:0] sqx2, sqy2;
  logic [35:0] rad3, rad4, rad5;
  logic [35:0] ppll4, pplh4, pphh4;
  logic [49:0] k1l4, k1h4;
  logic [71:0] r2_5;
  logic [51:0] t1_5, t1_6, t1_7, t1_8, t1_9;
  logic [35:0] p_l6 [4];
  logic [35:0] p_h6 [4];
  logic [49:0] k2p6 [4];
  logic [89:0] a7, b7;
  logic [103:0] k2s7;
  logic [74:0] r3s8;
  logic [47:0] t2_8, t2_9;
  logic [56:0] k3p9 [3];
  logic [42:0] t3_10;
  logic [53:0] t1s10, t2s10;
  logic [53:0] scale11;
  logic [52:0] smag12;
  logic [17:0] dxm12, dym12;
  logic        negx12, negy12, negx13, negy13, negx14, negy14;
  logic [44:0] pxl13, pyl13;
  logic [43:0] pxh13, pyh13;
  logic [61:0] pmx14, pmy14;
  logic        ovx14, ovy14;
  logic [63:0] vx15, vy15;
  logic [19:0] qx16, qy16;
  logic        vnegx16, vnegy16;

  // combinational intermediates
  logic [18:0] dx_in, dy_in;
  logic        ok_in;
  logic [37:0] sqx_full, sqy_full;
  logic [36:0] rad_sum;
  logic [67:0] k1_sum;
  logic [89:0] a_sum, b_sum;
  logic [103:0] k2_sum;
  logic [107:0] r3_full;
  logic [106:0] k3_sum;
  logic [53:0] t3s;
  logic [71:0] pmx_full, pmy_full;
  logic [63:0] c16x, c16y;
  logic [63:0] rndx, rndy;
  logic        fitx, fity;
  logic [24:0] row_base;
  logic [23:0] index_sum;

  localparam logic [53:0] SCALE_ONE = 54'd1 << 40;
  localparam logic [63:0] RND_POS = 64'd1 << 43;
  localparam logic [63:0] RND_NEG = RND_POS + 64'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd1024;
      frame_height <= 13'd1024;
      center_offset_x <= '0;
      center_offset_y <= '0;
      coeff_first <= '0;
      coeff_second <= '0;
      coeff_third <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     frame_width <= cfg_data[12:0];
        REG_FRAME_HEIGHT:    frame_height <= cfg_data[12:0];
        REG_CENTER_OFFSET_X: center_offset_x <= cfg_data[16:0];
        REG_CENTER_OFFSET_Y: center_offset_y <= cfg_data[16:0];
        REG_COEFF_FIRST:     coeff_first <= cfg_data;
        REG_COEFF_SECOND:    coeff_second <= cfg_data;
        REG_COEFF_THIRD:     coeff_third <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // derived settings; the user keeps them stable while items are in flight, the block does not enforce it
  always_comb begin
    wc = (frame_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : frame_width;
    hc = (frame_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : frame_height;
    cx = {2'b00, wc, 3'b000} + {center_offset_x[16], center_offset_x};
    cy = {2'b00, hc, 3'b000} + {center_offset_y[16], center_offset_y};
    k1_mag = coeff_first[31] ? (32'd0 - coeff_first) : coeff_first;
    k2_mag = coeff_second[31] ? (32'd0 - coeff_second) : coeff_second;
    k3_mag = coeff_third[31] ? (32'd0 - coeff_third) : coeff_third;
    c16x = {{6{cx[17]}}, cx, 40'd0};
    c16y = {{6{cy[17]}}, cy, 40'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      busy <= 1'b1;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start & ~busy};
      busy <= 1'b0;
    end
  end

  assign result_valid = vld[PIPE_DEPTH-1];

  always_comb begin
    ok_in = ({1'b0, pixel.pixel_x} < wc) && ({1'b0, pixel.pixel_y} < hc);
    dx_in = {3'b000, pixel.pixel_x, 4'b0000} - {cx[17], cx};
    dy_in = {3'b000, pixel.pixel_y, 4'b0000} - {cy[17], cy};
    sqx_full = $signed(dx1) * $signed(dx1);
    sqy_full = $signed(dy1) * $signed(dy1);
    rad_sum = {1'b0, sqx2} + {1'b0, sqy2};
    k1_sum = 68'(k1l4) + (68'(k1h4) << 18);
    a_sum = '0;
    b_sum = '0;
    k2_sum = '0;
    for (int i = 0; i < 4; i++) begin
      a_sum = a_sum + (90'(p_l6[i]) << (18 * i));
      b_sum = b_sum + (90'(p_h6[i]) << (18 * i));
      k2_sum = k2_sum + (104'(k2p6[i]) << (18 * i));
    end
    r3_full = 108'(a7) + (108'(b7) << 18);
    k3_sum = 107'(k3p9[0]) + (107'(k3p9[1]) << 25) + (107'(k3p9[2]) << 50);
    t3s = coeff_third[31] ? (54'd0 - 54'(t3_10)) : 54'(t3_10);
    pmx_full = 72'(pxl13) + (72'(pxh13) << 27);
    pmy_full = 72'(pyl13) + (72'(pyh13) << 27);
    rndx = vx15[63] ? (~vx15 + RND_NEG) : (vx15 + RND_POS);
    rndy = vy15[63] ? (~vy15 + RND_NEG) : (vy15 + RND_POS);
    fitx = (!vnegx16 || qx16 == 20'd0) && (qx16 < 20'(wc));
    fity = (!vnegy16 || qy16 == 20'd0) && (qy16 < 20'(hc));
    row_base = qy16[11:0] * wc;
    index_sum = row_base[23:0] + {12'd0, qx16[11:0]};
  end

  always_ff @(posedge clk) begin
    // offsets from the center
    ok1 <= ok_in;
    dx1 <= dx_in;
    dy1 <= dy_in;
    // squares
    ok2 <= ok1;
    dx2 <= dx1;
    dy2 <= dy1;
    sqx2 <= sqx_full[35:0];
    sqy2 <= sqy_full[35:0];
    // squared radius
    ok3 <= ok2;
    dx3 <= dx2;
    dy3 <= dy2;
    rad3 <= rad_sum[35:0];
    // partial products of r^2 and k1*r
    ok4 <= ok3;
    dx4 <= dx3;
    dy4 <= dy3;
    rad4 <= rad3;
    ppll4 <= rad3[17:0] * rad3[17:0];
    pplh4 <= rad3[17:0] * rad3[35:18];
    pphh4 <= rad3[35:18] * rad3[35:18];
    k1l4 <= k1_mag * rad3[17:0];
    k1h4 <= k1_mag * rad3[35:18];
    // r^2 and first term
    ok5 <= ok4;
    dx5 <= dx4;
    dy5 <= dy4;
    rad5 <= rad4;
    r2_5 <= 72'(ppll4) + (72'(pplh4) << 19) + (72'(pphh4) << 36);
    t1_5 <= k1_sum[67:16];
    // partial products of r^3 and k2*r^2
    ok6 <= ok5;
    dx6 <= dx5;
    dy6 <= dy5;
    t1_6 <= t1_5;
    for (int i = 0; i < 4; i++) begin
      p_l6[i] <= r2_5[18*i +: 18] * rad5[17:0];
      p_h6[i] <= r2_5[18*i +: 18] * rad5[35:18];
      k2p6[i] <= k2_mag * r2_5[18*i +: 18];
    end
    ok7 <= ok6;
    dx7 <= dx6;
    dy7 <= dy6;
    t1_7 <= t1_6;
    a7 <= a_sum;
    b7 <= b_sum;
    k2s7 <= k2_sum;
    // r^3 / 2^32 and second term
    ok8 <= ok7;
    dx8 <= dx7;
    dy8 <= dy7;
    t1_8 <= t1_7;
    r3s8 <= r3_full[106:32];
    t2_8 <= k2s7[103:56];
    // partial products of k3*r^3
    ok9 <= ok8;
    dx9 <= dx8;
    dy9 <= dy8;
    t1_9 <= t1_8;
    t2_9 <= t2_8;
    for (int i = 0; i < 3; i++) begin
      k3p9[i] <= k3_mag * r3s8[25*i +: 25];
    end
    // third term, signed first and second terms
    ok10 <= ok9;
    dx10 <= dx9;
    dy10 <= dy9;
    t3_10 <= k3_sum[106:64];
    t1s10 <= coeff_first[31] ? (54'd0 - 54'(t1_9)) : 54'(t1_9);
    t2s10 <= coeff_second[31] ? (54'd0 - 54'(t2_9)) : 54'(t2_9);
    // scale
    ok11 <= ok10;
    dx11 <= dx10;
    dy11 <= dy10;
    scale11 <= SCALE_ONE + t1s10 + t2s10 + t3s;
    // magnitudes and signs
    ok12 <= ok11;
    smag12 <= scale11[53] ? 53'(54'd0 - scale11) : scale11[52:0];
    dxm12 <= dx11[18] ? 18'(19'd0 - dx11) : dx11[17:0];
    dym12 <= dy11[18] ? 18'(19'd0 - dy11) : dy11[17:0];
    negx12 <= dx11[18] ^ scale11[53];
    negy12 <= dy11[18] ^ scale11[53];
    // offset times scale, partial products
    ok13 <= ok12;
    negx13 <= negx12;
    negy13 <= negy12;
    pxl13 <= dxm12 * smag12[26:0];
    pxh13 <= dxm12 * smag12[52:27];
    pyl13 <= dym12 * smag12[26:0];
    pyh13 <= dym12 * smag12[52:27];
    ok14 <= ok13;
    negx14 <= negx13;
    negy14 <= negy13;
    pmx14 <= pmx_full[61:0];
    pmy14 <= pmy_full[61:0];
    ovx14 <= |pmx_full[71:62];
    ovy14 <= |pmy_full[71:62];
    // back to frame coordinates
    ok15 <= ok14 & ~ovx14 & ~ovy14;
    vx15 <= (negx14 ? (64'd0 - 64'(pmx14)) : 64'(pmx14)) + c16x;
    vy15 <= (negy14 ? (64'd0 - 64'(pmy14)) : 64'(pmy14)) + c16y;
    // round half away from zero
    ok16 <= ok15;
    qx16 <= rndx[63:44];
    qy16 <= rndy[63:44];
    vnegx16 <= vx15[63];
    vnegy16 <= vy15[63];
    // frame check and linear index
    if (ok16 && fitx && fity) begin
      result.mapped_x <= qx16[11:0];
      result.mapped_y <= qy16[11:0];
      result.mapped_index <= index_sum;
      result.in_frame <= 1'b1;
    end else begin
      result <= '0;
    end
  end

endmodule

// ===== hdl/rldr_check.sv =====
module rldr_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input rldr_pkg::result_t result
);
  import rldr_pkg::*;

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH result_valid)
    else $error("accepted pixel produced no result");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without accepted pixel");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.in_frame) |->
      (result.mapped_x == 12'd0 && result.mapped_y == 12'd0 &&
       result.mapped_index == 24'd0))
    else $error("out of frame result carries nonzero fields");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> (!result_valid && busy))
    else $error("reset did not flush the pipeline");

  a_busy_release: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy high outside reset recovery");

endmodule

bind radial_lens_distortion_remap_core rldr_check u_rldr_check (.*);

// ===== dv/radial_lens_distortion_remap_core_tb.sv =====
`timescale 1ns / 1ps

module radial_lens_distortion_remap_core_tb;
  import rldr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int SCRIPT_LEN = 30;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam result_t OFF_FRAME = '0;

  typedef enum bit {ROW_PIXEL, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    pixel_t                 pix;
    logic                   typed;
    result_t                want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pixel_t pixel = '0;
  logic result_valid;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copy for the predictor
  logic [12:0] lens_width = 13'd1024;
  logic [12:0] lens_height = 13'd1024;
  logic signed [16:0] lens_off_x = '0;
  logic signed [16:0] lens_off_y = '0;
  logic signed [31:0] lens_k1 = '0;
  logic signed [31:0] lens_k2 = '0;
  logic signed [31:0] lens_k3 = '0;

  result_t corrected_due[$];
  result_t oldest;
  int bad_results = 0;
  int cycle_count = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b1,
      '{12'd0, 12'd0, 24'd0, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd1023, 12'd1023}, 1'b1,
      '{12'd1023, 12'd1023, 24'd1048575, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd1024, 12'd0}, 1'b1, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd1024}, 1'b1, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd4095, 12'd4095}, 1'b1, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd511, 12'd777}, 1'b1,
      '{12'd511, 12'd777, 24'd796159, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd512, 12'd512}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_FRAME_WIDTH, 32'd8191, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_FRAME_HEIGHT, 32'd4096, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd4095, 12'd4095}, 1'b1,
      '{12'd4095, 12'd4095, 24'd16777215, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b1,
      '{12'd0, 12'd0, 24'd0, 1'b1}},
    '{ROW_CONFIG, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b1, OFF_FRAME},
    '{ROW_CONFIG, REG_FRAME_WIDTH, 32'd4096, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_CENTER_OFFSET_X, 32'h0000_FFFF, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_CENTER_OFFSET_Y, 32'hFFFF_0000, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd100, 12'd200}, 1'b1,
      '{12'd100, 12'd200, 24'd819300, 1'b1}},
    '{ROW_CONFIG, REG_COEFF_FIRST, 32'h7FFF_FFFF, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b1, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd4095, 12'd2048}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_COEFF_FIRST, 32'h8000_0000, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd0}, 1'b1, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd4095, 12'd4095}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_COEFF_FIRST, 32'd0, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_COEFF_SECOND, 32'h7FFF_FFFF, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd2048, 12'd2048}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_COEFF_THIRD, 32'h8000_0000, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd0, 12'd4095}, 1'b0, OFF_FRAME},
    '{ROW_CONFIG, REG_UNMAPPED, 32'hFFFF_FFFF, '{12'd0, 12'd0}, 1'b0, OFF_FRAME},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 32'd0, '{12'd1, 12'd1}, 1'b0, OFF_FRAME}
  };

  radial_lens_distortion_remap_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // one radial term, truncated toward zero
  function automatic longint radial_term(logic signed [31:0] k, logic [127:0] pw,
                                         int unsigned sh);
    logic [127:0] prod;
    logic [63:0] m;
    prod = (128'(k < 0 ? -longint'(k) : longint'(k)) * pw) >> sh;
    m = prod[63:0];
    return k < 0 ? -longint'(m) : longint'(m);
  endfunction

  // scaled coordinate rounded half away from zero; 0 when far out of range
  function automatic bit scale_axis(longint d, longint c, longint s, output longint q);
    logic [127:0] prod;
    logic [63:0] vm;
    logic [63:0] qm;
    longint v;
    bit neg;
    q = 0;
    neg = (d < 0) != (s < 0);
    prod = 128'(d < 0 ? -d : d) * 128'(s < 0 ? -s : s);
    if (prod[127:62] != '0) return 1'b0;
    v = (neg ? -longint'(prod[63:0]) : longint'(prod[63:0])) + c * (longint'(1) << 40);
    vm = v < 0 ? -v : v;
    qm = (vm + (64'd1 << 43)) >> 44;
    q = v < 0 ? -longint'(qm) : longint'(qm);
    return 1'b1;
  endfunction

  function automatic result_t correct_pixel(pixel_t p);
    longint w, h, px, py, cx, cy, dx, dy, s, xr, yr;
    logic [127:0] r1, r2, r3;
    result_t r;
    r = '0;
    w = (lens_width > MAX_DIM) ? MAX_DIM : lens_width;
    h = (lens_height > MAX_DIM) ? MAX_DIM : lens_height;
    px = p.pixel_x;
    py = p.pixel_y;
    if (px >= w || py >= h) return r;
    cx = w * 8 + longint'(lens_off_x);
    cy = h * 8 + longint'(lens_off_y);
    dx = px * 16 - cx;
    dy = py * 16 - cy;
    r1 = 128'(dx * dx + dy * dy);
    r2 = r1 * r1;
    r3 = (r2 * r1) >> 32;
    s = (longint'(1) << 40) + radial_term(lens_k1, r1, 16) + radial_term(lens_k2, r2, 56)
      + radial_term(lens_k3, r3, 64);
    if (!scale_axis(dx, cx, s, xr) || !scale_axis(dy, cy, s, yr)) return r;
    if (xr < 0 || xr >= w || yr < 0 || yr >= h) return r;
    r.mapped_x = 12'(xr);
    r.mapped_y = 12'(yr);
    r.mapped_index = 24'(yr * w + xr);
    r.in_frame = 1'b1;
    return r;
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 13'($urandom_range(0, 8191));
      1: return 13'($urandom_range(1, 16));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 1023) - 512;
  endfunction

  function automatic logic [31:0] pick_coeff();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1) == 1) v = -v;
    if ($urandom_range(0, 7) == 0) v = '0;
    return v;
  endfunction

  // unused upper bits of the write data must be ignored
  function automatic logic [31:0] with_junk(logic [31:0] v, int bits);
    return ($urandom_range(0, 3) == 0) ? (v | ($urandom << bits)) : v;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_FRAME_WIDTH: lens_width = value[12:0];
      REG_FRAME_HEIGHT: lens_height = value[12:0];
      REG_CENTER_OFFSET_X: lens_off_x = value[16:0];
      REG_CENTER_OFFSET_Y: lens_off_y = value[16:0];
      REG_COEFF_FIRST: lens_k1 = value;
      REG_COEFF_SECOND: lens_k2 = value;
      REG_COEFF_THIRD: lens_k3 = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t p, logic typed, result_t want, int gap);
    cfg_write <= 1'b0;
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    corrected_due.push_back(typed ? want : correct_pixel(p));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (corrected_due.size() != 0);
  endtask

  task automatic compare_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      bad_results++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (corrected_due.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, result);
        bad_results++;
      end else begin
        oldest = corrected_due.pop_front();
        compare_field("mapped_x", oldest.mapped_x, result.mapped_x);
        compare_field("mapped_y", oldest.mapped_y, result.mapped_y);
        compare_field("mapped_index", oldest.mapped_index, result.mapped_index);
        compare_field("in_frame", oldest.in_frame, result.in_frame);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    int gap;
    int dim_w;
    int dim_h;
    bit burst;
    pixel_t p;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_reg(script[i].index, script[i].data);
      end else begin
        send_pixel(script[i].pix, script[i].typed, script[i].want, $urandom_range(0, 6));
      end
    end

    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      write_reg(REG_FRAME_WIDTH, with_junk(pick_dim(), 13));
      write_reg(REG_FRAME_HEIGHT, with_junk(pick_dim(), 13));
      write_reg(REG_CENTER_OFFSET_X, pick_offset());
      write_reg(REG_CENTER_OFFSET_Y, pick_offset());
      write_reg(REG_COEFF_FIRST, pick_coeff());
      write_reg(REG_COEFF_SECOND, pick_coeff());
      write_reg(REG_COEFF_THIRD, pick_coeff());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, $urandom);
      dim_w = (lens_width > MAX_DIM) ? MAX_DIM : lens_width;
      dim_h = (lens_height > MAX_DIM) ? MAX_DIM : lens_height;
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 160);
      repeat (n) begin
        p.pixel_x = 12'($urandom);
        p.pixel_y = 12'($urandom);
        // mostly pixels inside the frame, the rest anywhere
        if ($urandom_range(0, 7) != 0 && dim_w > 0 && dim_h > 0) begin
          p.pixel_x = 12'($urandom_range(0, dim_w - 1));
          p.pixel_y = 12'($urandom_range(0, dim_h - 1));
        end
        gap = (burst || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 6);
        send_pixel(p, 1'b0, OFF_FRAME, gap);
        sent++;
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (bad_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
